// ----- sv/can_bt_pkg.sv -----
// ---------------------------------------------------------------------------
// can_bt_pkg
// Shared types, field widths and the quanta-to-segment lookup for the CAN
// bit timing search.
// ---------------------------------------------------------------------------
package can_bt_pkg;

    localparam int CLOCK_W  = 32;
    localparam int RATE_W   = 24;
    localparam int PRESC_W  = 9;
    localparam int SEG1_W   = 5;
    localparam int SEG2_W   = 4;
    localparam int JUMP_W   = 3;
    localparam int QUOT_W   = 5;

    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 32'd80000000;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // Status word from the shared divider to the sequencer
    typedef struct packed {
        logic              done;
        logic              over;   // quotient is 32 or more
        logic [QUOT_W-1:0] quot;
    } div_status_t;

    typedef struct packed {
        logic              ok;
        logic [SEG1_W-1:0] seg1;
        logic [SEG2_W-1:0] seg2;
        logic [JUMP_W-1:0] jump;
    } fit_t;

    // seg1 = floor(8q/10) - 1 must lie in 1..16, seg2 = q - 1 - seg1 in 1..8,
    // q in 4..25; only q = 4..22 survive. Jump width is min(seg2, 4).
    function automatic fit_t fit_lookup(input logic [QUOT_W-1:0] q);
        fit_t f;
        f = '0;
        f.ok = 1'b1;
        case (q)
            5'd4:    begin f.seg1 = 5'd2;  f.seg2 = 4'd1; end
            5'd5:    begin f.seg1 = 5'd3;  f.seg2 = 4'd1; end
            5'd6:    begin f.seg1 = 5'd3;  f.seg2 = 4'd2; end
            5'd7:    begin f.seg1 = 5'd4;  f.seg2 = 4'd2; end
            5'd8:    begin f.seg1 = 5'd5;  f.seg2 = 4'd2; end
            5'd9:    begin f.seg1 = 5'd6;  f.seg2 = 4'd2; end
            5'd10:   begin f.seg1 = 5'd7;  f.seg2 = 4'd2; end
            5'd11:   begin f.seg1 = 5'd7;  f.seg2 = 4'd3; end
            5'd12:   begin f.seg1 = 5'd8;  f.seg2 = 4'd3; end
            5'd13:   begin f.seg1 = 5'd9;  f.seg2 = 4'd3; end
            5'd14:   begin f.seg1 = 5'd10; f.seg2 = 4'd3; end
            5'd15:   begin f.seg1 = 5'd11; f.seg2 = 4'd3; end
            5'd16:   begin f.seg1 = 5'd11; f.seg2 = 4'd4; end
            5'd17:   begin f.seg1 = 5'd12; f.seg2 = 4'd4; end
            5'd18:   begin f.seg1 = 5'd13; f.seg2 = 4'd4; end
            5'd19:   begin f.seg1 = 5'd14; f.seg2 = 4'd4; end
            5'd20:   begin f.seg1 = 5'd15; f.seg2 = 4'd4; end
            5'd21:   begin f.seg1 = 5'd15; f.seg2 = 4'd5; end
            5'd22:   begin f.seg1 = 5'd16; f.seg2 = 4'd5; end
            default: f.ok = 1'b0;
        endcase
        f.jump = (f.seg2 < 4'd4) ? f.seg2[JUMP_W-1:0] : 3'd4;
        return f;
    endfunction

endpackage

// ----- sv/can_bt_div.sv -----
// ---------------------------------------------------------------------------
// can_bt_div
// Shared restoring divider: one compare and subtract a cycle, six steps,
// giving a five-bit quotient of clock by divisor and an overflow flag.
// ---------------------------------------------------------------------------
module can_bt_div #(
    parameter int DW = 34
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [can_bt_pkg::CLOCK_W-1:0]   dividend,
    input  logic [DW-1:0]                    divisor,
    output can_bt_pkg::div_status_t          stat
);
    import can_bt_pkg::*;

    localparam int TW = DW + QUOT_W;
    localparam int XW = ((TW > CLOCK_W) ? TW : CLOCK_W) + 1;
    localparam logic [2:0] K_TOP = 3'(QUOT_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                over_reg, over_next;
    logic [2:0]          k_reg, k_next;
    logic [CLOCK_W-1:0]  r_reg, r_next;
    logic [QUOT_W-1:0]   q_reg, q_next;

    logic [TW-1:0]       trial;
    logic [XW-1:0]       diff;
    logic                ge;

    assign trial = TW'(divisor) << k_reg;
    assign diff  = XW'(r_reg) - XW'(trial);
    assign ge    = ~diff[XW-1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        over_next = over_reg;
        k_next    = k_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            over_next = 1'b0;
            k_next    = K_TOP;
            r_next    = dividend;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (ge)
                r_next = diff[CLOCK_W-1:0];
            if (k_reg == K_TOP)
                over_next = ge;
            else
                q_next = {q_reg[QUOT_W-2:0], ge};
            if (k_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                k_next = k_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        over_reg <= over_next;
        k_reg    <= k_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
    end

    assign stat.done = done_reg;
    assign stat.over = over_reg;
    assign stat.quot = q_reg;

endmodule

// ----- sv/can_bit_timing_search.sv -----
// ---------------------------------------------------------------------------
// can_bit_timing_search
// Searches prescalers from 1 upward for the first CAN bit timing that fits
// the requested bit rate at the configured controller clock.
// ---------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | bitrate
//  output   | out_valid / out_stall| status, prescaler_code, segment_one,
//           |                      | segment_two, jump_width
//  config   | cfg_wr_en            | cfg_wr_data (clock_hz)
//
//  Each prescaler trial loads the shared divider, lets it run its six
//  compare/subtract steps and then checks the registered quotient. A word
//  therefore costs p trials when prescaler p wins and MAX_PRESCALER trials
//  when none fits; a zero bit rate is answered without any trial.
//  Reset restores clock_hz to 80 MHz and empties the output register.
//  in_stall is high from acceptance until the result is handed to the
//  output register, which holds it under out_stall while a new word enters.
//
module can_bit_timing_search #(
    parameter int MAX_PRESCALER = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [can_bt_pkg::CLOCK_W-1:0]     cfg_wr_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [can_bt_pkg::RATE_W-1:0]      bitrate,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               status,
    output logic [can_bt_pkg::PRESC_W-1:0]     prescaler_code,
    output logic [can_bt_pkg::SEG1_W-1:0]      segment_one,
    output logic [can_bt_pkg::SEG2_W-1:0]      segment_two,
    output logic [can_bt_pkg::JUMP_W-1:0]      jump_width
);
    import can_bt_pkg::*;

    // Prescaler counter holds 1..MAX_PRESCALER; divisor is prescaler * rate
    localparam int PW = $clog2(MAX_PRESCALER + 1);
    localparam int DW = PW + RATE_W;
    localparam logic [PW-1:0] P_LAST = PW'(MAX_PRESCALER);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CLOCK_W-1:0]  clock_hz_reg;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [PW-1:0]       p_reg, p_next;
    logic [DW-1:0]       d_reg, d_next;

    // result waiting for the output register
    logic                res_status_reg, res_status_next;
    logic [PRESC_W-1:0]  res_presc_reg, res_presc_next;
    logic [SEG1_W-1:0]   res_seg1_reg, res_seg1_next;
    logic [SEG2_W-1:0]   res_seg2_reg, res_seg2_next;
    logic [JUMP_W-1:0]   res_jump_reg, res_jump_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic                out_status_reg;
    logic [PRESC_W-1:0]  out_presc_reg;
    logic [SEG1_W-1:0]   out_seg1_reg;
    logic [SEG2_W-1:0]   out_seg2_reg;
    logic [JUMP_W-1:0]   out_jump_reg;

    div_status_t         div_stat;
    fit_t                fit;
    logic                found;
    logic                div_start;
    logic                in_take;
    logic                out_load;
    logic [PW-1:0]       p_minus_one;
    logic [PW+PRESC_W-1:0] p_code_ext;

    can_bt_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clock_hz_reg),
        .divisor  (d_reg),
        .stat     (div_stat)
    );

    // Check the quotient: it must not overflow and must map to valid segments
    assign fit         = fit_lookup(div_stat.quot);
    assign found       = ~div_stat.over & fit.ok;
    assign p_minus_one = p_reg - PW'(1);
    assign p_code_ext  = {{PRESC_W{1'b0}}, p_minus_one};

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid & ~in_stall;
    assign div_start = (state_reg == S_START);
    assign out_load  = (state_reg == S_OUT) & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        state_next      = state_reg;
        rate_next       = rate_reg;
        p_next          = p_reg;
        d_next          = d_reg;
        res_status_next = res_status_reg;
        res_presc_next  = res_presc_reg;
        res_seg1_next   = res_seg1_reg;
        res_seg2_next   = res_seg2_reg;
        res_jump_next   = res_jump_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    // start at prescaler 1; a zero rate is answered at once
                    rate_next       = bitrate;
                    p_next          = PW'(1);
                    d_next          = DW'(bitrate);
                    res_status_next = STATUS_INVALID;
                    res_presc_next  = '0;
                    res_seg1_next   = '0;
                    res_seg2_next   = '0;
                    res_jump_next   = '0;
                    state_next      = (bitrate == '0) ? S_OUT : S_START;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (found)
                    begin
                        res_status_next = STATUS_OK;
                        res_presc_next  = p_code_ext[PRESC_W-1:0];
                        res_seg1_next   = fit.seg1;
                        res_seg2_next   = fit.seg2;
                        res_jump_next   = fit.jump;
                        state_next      = S_OUT;
                    end
                    else if (p_reg == P_LAST)
                        state_next = S_OUT;
                    else
                    begin
                        // advance to the next prescaler
                        p_next     = p_reg + PW'(1);
                        d_next     = d_reg + DW'(rate_reg);
                        state_next = S_START;
                    end
                end
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg & ~out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clock_hz_reg  <= CLOCK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                clock_hz_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg       <= rate_next;
        p_reg          <= p_next;
        d_reg          <= d_next;
        res_status_reg <= res_status_next;
        res_presc_reg  <= res_presc_next;
        res_seg1_reg   <= res_seg1_next;
        res_seg2_reg   <= res_seg2_next;
        res_jump_reg   <= res_jump_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_presc_reg  <= res_presc_reg;
            out_seg1_reg   <= res_seg1_reg;
            out_seg2_reg   <= res_seg2_reg;
            out_jump_reg   <= res_jump_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign prescaler_code = out_presc_reg;
    assign segment_one    = out_seg1_reg;
    assign segment_two    = out_seg2_reg;
    assign jump_width     = out_jump_reg;

    // A new result word only appears after leaving the hand-off state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_OUT)
        else $error("result word appeared without a hand-off");

    // An invalid answer carries all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_INVALID) |->
            (prescaler_code == '0 && segment_one == '0 &&
             segment_two == '0 && jump_width == '0))
        else $error("invalid result with non-zero fields");

    // A found timing has legal segments and a consistent jump width
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_OK) |->
            (segment_one != '0 && segment_one <= 5'd16 &&
             segment_two != '0 && segment_two <= 4'd8 &&
             jump_width != '0 && jump_width <= 3'd4 &&
             {1'b0, jump_width} <= segment_two))
        else $error("found timing out of range");

    // The prescaler counter stays within 1..MAX_PRESCALER during a search
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START || state_reg == S_WAIT) |->
            (p_reg != '0 && p_reg <= P_LAST))
        else $error("prescaler counter out of range");

    // The divider is only started from the load state, never mid-division
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == S_WAIT && !div_stat.done))
        else $error("divider start sequencing broken");

endmodule
